### hdl/rbs_pkg.sv
// Shared types and constants of the roaring bitmap set.
`default_nettype none
package rbs_pkg;

  localparam int unsigned KeyW       = 16;
  localparam int unsigned LowW       = 16;
  localparam int unsigned TotalW     = 21;
  localparam int unsigned SizeW      = 17;
  localparam int unsigned DenseWords = 1024;
  localparam int unsigned WordW      = 64;
  localparam int unsigned QDepth     = 2;

  localparam logic [1:0] KindAdd   = 2'd0;
  localparam logic [1:0] KindTest  = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_TEST,
    OP_CLEAR,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [KeyW-1:0]  key;
    logic [LowW-1:0]  low;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISP,
    ST_BS_RD,
    ST_BS_CMP,
    ST_CHK_CMP,
    ST_SHIFT,
    ST_INS,
    ST_CLR,
    ST_LOAD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

### hdl/rbs_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module rbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output      logic [WIDTH-1:0]                              rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/rbs_front.sv
// Front end: takes items, decodes the kind, queues them for the engine.
`default_nettype none
module rbs_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire logic [1:0]     kind_i,
  input  wire logic [31:0]    value_i,
  output      logic           item_valid_o,
  output      rbs_pkg::item_t item_o,
  input  wire logic           item_ready_i
);
  import rbs_pkg::*;

  item_t      q_mem_q [QDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  item_t      dec;
  logic       push, pop;

  always_comb begin
    dec.key = value_i[31:16];
    dec.low = value_i[15:0];
    unique case (kind_i)
      KindAdd:   dec.op = OP_ADD;
      KindTest:  dec.op = OP_TEST;
      KindClear: dec.op = OP_CLEAR;
      default:   dec.op = OP_NONE;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'(QDepth));
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_mem_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end
endmodule
`default_nettype wire

### hdl/rbs_back.sv
// Engine: slot lookup, sorted array insert/search, dense conversion and bit ops.
`default_nettype none
module rbs_back #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned ARRAY_LIMIT = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        item_valid_i,
  input  wire rbs_pkg::item_t              item_i,
  output      logic                        item_ready_o,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic                        found_o,
  output      logic [rbs_pkg::TotalW-1:0]  total_count_o,
  output      logic                        dropped_o
);
  import rbs_pkg::*;

  localparam int unsigned SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW     = $clog2(ARRAY_LIMIT + 1);
  localparam int unsigned CW     = (LW > 11) ? LW : 11;
  localparam int unsigned SDepth = SLOTS * ARRAY_LIMIT;
  localparam int unsigned DDepth = SLOTS * DenseWords;
  localparam int unsigned AW     = (SDepth > 1) ? $clog2(SDepth) : 1;
  localparam int unsigned DAW    = (DDepth > 1) ? $clog2(DDepth) : 1;
  localparam logic [SW-1:0] LastSlot = SW'(SLOTS - 1);

  // slot table
  logic [SLOTS-1:0]  used_q, sl_dense_q;
  logic [SizeW-1:0]  sl_size_q [SLOTS];
  logic [KeyW-1:0]   sl_key_q  [SLOTS];

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [LowW-1:0]   low_q, low_d;
  logic [SW-1:0]     sidx_q, sidx_d, free_q, free_d, cur_q, cur_d;
  logic              free_vld_q, free_vld_d;
  logic              sdense_q, sdense_d;
  logic [SizeW-1:0]  ssize_q, ssize_d;
  logic [LW-1:0]     lo_q, lo_d, hi_q, hi_d, n_q, n_d;
  logic [CW-1:0]     i_q, i_d;
  logic              wpend_q, wpend_d;
  logic [AW-1:0]     waddr_q, waddr_d;
  logic              rv_q, rv_d, have_q, have_d;
  logic [9:0]        cw_q, cw_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic              found_q, found_d, dropped_q, dropped_d;
  logic [TotalW-1:0] total_q, total_d;

  // slot table controls
  logic              clr_all, alloc_we, size_we, dense_we;
  logic [SW-1:0]     alloc_slot;
  logic [SizeW-1:0]  size_val;

  // memory ports
  logic              s_we, d_we;
  logic [AW-1:0]     s_waddr, s_raddr, sbase;
  logic [DAW-1:0]    d_waddr, d_raddr, dbase;
  logic [LowW-1:0]   s_wdata, s_rdata;
  logic [WordW-1:0]  d_wdata, d_rdata, bitm;
  logic [LW-1:0]     mid, n_lim;
  logic [9:0]        widx;
  logic              dbit;

  assign sbase = AW'(cur_q) * AW'(ARRAY_LIMIT);
  assign dbase = DAW'(cur_q) * DAW'(DenseWords);
  assign mid   = lo_q + ((hi_q - lo_q) >> 1);
  assign n_lim = (ssize_q > SizeW'(ARRAY_LIMIT)) ? LW'(ARRAY_LIMIT) : LW'(ssize_q);
  assign widx  = s_rdata[15:6];
  assign bitm  = WordW'(1) << s_rdata[5:0];
  assign dbit  = d_rdata[low_q[5:0]];

  rbs_ram #(.WIDTH(LowW), .DEPTH(SDepth)) u_sorted (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  rbs_ram #(.WIDTH(WordW), .DEPTH(DDepth)) u_dense (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  always_comb begin
    state_d = state_q;  op_d = op_q;  key_d = key_q;  low_d = low_q;
    sidx_d = sidx_q;  free_d = free_q;  free_vld_d = free_vld_q;  cur_d = cur_q;
    sdense_d = sdense_q;  ssize_d = ssize_q;
    lo_d = lo_q;  hi_d = hi_q;  n_d = n_q;  i_d = i_q;
    wpend_d = wpend_q;  waddr_d = waddr_q;
    rv_d = rv_q;  have_d = have_q;  cw_d = cw_q;  acc_d = acc_q;
    found_d = found_q;  dropped_d = dropped_q;  total_d = total_q;
    clr_all = 1'b0;  alloc_we = 1'b0;  alloc_slot = '0;
    size_we = 1'b0;  size_val = '0;  dense_we = 1'b0;
    s_we = 1'b0;  s_waddr = '0;  s_wdata = '0;  s_raddr = '0;
    d_we = 1'b0;  d_waddr = '0;  d_wdata = '0;  d_raddr = '0;
    item_ready_o = 1'b0;
    out_valid_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          op_d = item_i.op;  key_d = item_i.key;  low_d = item_i.low;
          found_d = 1'b0;  dropped_d = 1'b0;
          sidx_d = '0;  free_vld_d = 1'b0;
          unique case (item_i.op)
            OP_ADD, OP_TEST: state_d = ST_SCAN;
            OP_CLEAR: begin
              clr_all = 1'b1;
              total_d = '0;
              state_d = ST_OUT;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_SCAN: begin
        if (used_q[sidx_q] && (sl_key_q[sidx_q] == key_q)) begin
          cur_d    = sidx_q;
          sdense_d = sl_dense_q[sidx_q];
          ssize_d  = sl_size_q[sidx_q];
          state_d  = ST_DISP;
        end else begin
          if (!used_q[sidx_q] && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_d     = sidx_q;
          end
          if (sidx_q == LastSlot) begin
            if ((op_q == OP_ADD) && (free_vld_q || !used_q[sidx_q])) begin
              alloc_slot = free_vld_q ? free_q : sidx_q;
              alloc_we   = 1'b1;
              cur_d      = alloc_slot;
              sdense_d   = 1'b0;
              ssize_d    = '0;
              state_d    = ST_DISP;
            end else begin
              dropped_d = (op_q == OP_ADD);
              state_d   = ST_OUT;
            end
          end else begin
            sidx_d = sidx_q + SW'(1);
          end
        end
      end
      ST_DISP: begin
        if (sdense_q) begin
          state_d = ST_DN_RD;
        end else if ((op_q == OP_ADD) && (ssize_q >= SizeW'(ARRAY_LIMIT))) begin
          i_d     = '0;
          state_d = ST_CLR;
        end else begin
          lo_d = '0;  hi_d = n_lim;  n_d = n_lim;
          state_d = ST_BS_RD;
        end
      end
      ST_BS_RD: begin
        if (lo_q < hi_q) begin
          s_raddr = sbase + AW'(mid);
          state_d = ST_BS_CMP;
        end else if (lo_q < n_q) begin
          s_raddr = sbase + AW'(lo_q);
          state_d = ST_CHK_CMP;
        end else if (op_q == OP_ADD) begin
          i_d = CW'(n_q);  wpend_d = 1'b0;
          state_d = ST_SHIFT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_BS_CMP: begin
        if (s_rdata < low_q) lo_d = mid + LW'(1);
        else                 hi_d = mid;
        state_d = ST_BS_RD;
      end
      ST_CHK_CMP: begin
        if (s_rdata == low_q) begin
          found_d = (op_q == OP_TEST);
          state_d = ST_OUT;
        end else if (op_q == OP_ADD) begin
          i_d = CW'(n_q);  wpend_d = 1'b0;
          state_d = ST_SHIFT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SHIFT: begin
        // read entry i-1 while writing the one fetched last cycle to its new place
        s_we    = wpend_q;
        s_waddr = waddr_q;
        s_wdata = s_rdata;
        if (i_q > CW'(lo_q)) begin
          s_raddr = sbase + AW'(i_q - CW'(1));
          waddr_d = sbase + AW'(i_q);
          wpend_d = 1'b1;
          i_d     = i_q - CW'(1);
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) state_d = ST_INS;
        end
      end
      ST_INS: begin
        s_we     = 1'b1;
        s_waddr  = sbase + AW'(lo_q);
        s_wdata  = low_q;
        size_we  = 1'b1;
        size_val = ssize_q + SizeW'(1);
        total_d  = total_q + TotalW'(1);
        state_d  = ST_OUT;
      end
      ST_CLR: begin
        d_we    = 1'b1;
        d_waddr = dbase + DAW'(i_q);
        d_wdata = '0;
        if (i_q == CW'(DenseWords - 1)) begin
          i_d = '0;  rv_d = 1'b0;  have_d = 1'b0;
          state_d = ST_LOAD;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      ST_LOAD: begin
        // array is sorted: gather bits per word, write a word when the index moves on
        if (i_q < CW'(ARRAY_LIMIT)) begin
          s_raddr = sbase + AW'(i_q);
          i_d     = i_q + CW'(1);
          rv_d    = 1'b1;
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          if (have_q && (widx != cw_q)) begin
            d_we    = 1'b1;
            d_waddr = dbase + DAW'(cw_q);
            d_wdata = acc_q;
            acc_d   = bitm;
          end else begin
            acc_d = (have_q ? acc_q : '0) | bitm;
          end
          cw_d   = widx;
          have_d = 1'b1;
        end else if (i_q == CW'(ARRAY_LIMIT)) begin
          d_we     = have_q;
          d_waddr  = dbase + DAW'(cw_q);
          d_wdata  = acc_q;
          dense_we = 1'b1;
          sdense_d = 1'b1;
          state_d  = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        d_raddr = dbase + DAW'(low_q[15:6]);
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (op_q == OP_TEST) begin
          found_d = dbit;
        end else if (!dbit) begin
          d_we     = 1'b1;
          d_waddr  = dbase + DAW'(low_q[15:6]);
          d_wdata  = d_rdata | (WordW'(1) << low_q[5:0]);
          size_we  = 1'b1;
          size_val = ssize_q + SizeW'(1);
          total_d  = total_q + TotalW'(1);
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign found_o       = found_q;
  assign dropped_o     = dropped_q;
  assign total_count_o = total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      used_q  <= '0;
      sl_dense_q <= '0;
      for (int k = 0; k < SLOTS; k++) sl_size_q[k] <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (clr_all) begin
        used_q     <= '0;
        sl_dense_q <= '0;
        for (int k = 0; k < SLOTS; k++) sl_size_q[k] <= '0;
      end else begin
        if (alloc_we) begin
          used_q[alloc_slot]     <= 1'b1;
          sl_dense_q[alloc_slot] <= 1'b0;
          sl_size_q[alloc_slot]  <= '0;
        end
        if (size_we)  sl_size_q[cur_q]  <= size_val;
        if (dense_we) sl_dense_q[cur_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_we) sl_key_q[alloc_slot] <= key_q;
    op_q <= op_d;  key_q <= key_d;  low_q <= low_d;
    sidx_q <= sidx_d;  free_q <= free_d;  free_vld_q <= free_vld_d;  cur_q <= cur_d;
    sdense_q <= sdense_d;  ssize_q <= ssize_d;
    lo_q <= lo_d;  hi_q <= hi_d;  n_q <= n_d;  i_q <= i_d;
    wpend_q <= wpend_d;  waddr_q <= waddr_d;
    rv_q <= rv_d;  have_q <= have_d;  cw_q <= cw_d;  acc_q <= acc_d;
    found_q <= found_d;  dropped_q <= dropped_d;
  end
endmodule
`default_nettype wire

### hdl/roaring_bitmap_set_top.sv
// Top level of the roaring bitmap set: front queue plus execution engine.
`default_nettype none
// A set of 32-bit values kept as a hybrid bitmap. The upper 16 bits of a
// value pick one of SLOTS container slots (taken in index order, released
// only by clear); each slot holds its low halves either as a sorted array of
// up to ARRAY_LIMIT entries or as a 65536-bit dense map. kind 0 adds, kind 1
// tests membership, kind 2 empties the set, kind 3 does nothing. Every item
// returns one result with found, dropped (add refused, slot table full) and
// the running element count. Items are queued two deep at the front, so up to
// two items are taken in while a result waits on the output. The engine works
// on one item at a time, in these steps:
//   slot lookup        : linear scan of the slot table
//   array test         : binary search, one RAM read per step
//   array insert       : search plus the pipelined shift through the sorted
//                        array RAM and the final write
//   array to dense     : wipe the slot's map, load it from the array, then a
//                        dense add
//   dense add or test  : read of one 64-bit word, written back by an add of a new value
//   clear, kind 3      : straight to the result
// then the result handshake. No clearing pass after reset.
module roaring_bitmap_set_top #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned ARRAY_LIMIT = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [31:0]                 value_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic                        found_o,
  output      logic [rbs_pkg::TotalW-1:0]  total_count_o,
  output      logic                        dropped_o
);
  import rbs_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  // front: decode and queue
  rbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  // back: slot table, array and dense stores, result register
  rbs_back #(
    .SLOTS       (SLOTS),
    .ARRAY_LIMIT (ARRAY_LIMIT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_ready_o  (item_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .total_count_o (total_count_o),
    .dropped_o     (dropped_o)
  );
endmodule
`default_nettype wire

### bench/rbs_result_check.sv
// Result checker of the roaring bitmap set: watches both channels, predicts, compares.
module rbs_result_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [1:0]                 kind_i,
  input  logic [31:0]                value_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       found_i,
  input  logic [rbs_pkg::TotalW-1:0] total_count_i,
  input  logic                       dropped_i,
  output int                         pending_o,
  output int                         fails_o
);
  import rbs_pkg::*;

  localparam int unsigned NumSlots = 16;

  typedef struct {
    logic              found;
    logic [TotalW-1:0] total;
    logic              dropped;
  } set_result_t;

  // Shadow copy of the set: slot table plus one membership map per slot.
  logic [KeyW-1:0]   slot_key_q  [NumSlots];
  bit                slot_used_q [NumSlots];
  bit                members_q   [NumSlots][bit [LowW-1:0]];
  logic [TotalW-1:0] element_cnt_q;
  set_result_t       expected_results[$];
  int                fail_cnt = 0;

  function automatic int lookup_slot(logic [KeyW-1:0] key);
    for (int s = 0; s < NumSlots; s++)
      if (slot_used_q[s] && slot_key_q[s] == key) return s;
    return -1;
  endfunction

  // Array/dense form never shows at the outputs, so plain set semantics suffice.
  function automatic set_result_t apply_set_op(op_e op, logic [31:0] value);
    set_result_t     res;
    logic [KeyW-1:0] key;
    logic [LowW-1:0] low;
    int              s;
    key = value[31:16];
    low = value[15:0];
    res.found   = 1'b0;
    res.dropped = 1'b0;
    case (op)
      OP_ADD: begin
        s = lookup_slot(key);
        if (s < 0) begin
          for (int i = 0; i < NumSlots; i++)
            if (!slot_used_q[i]) begin
              s = i;
              break;
            end
          if (s < 0) res.dropped = 1'b1;
          else begin
            slot_used_q[s] = 1'b1;
            slot_key_q[s]  = key;
            members_q[s].delete();
          end
        end
        if (s >= 0 && !members_q[s].exists(low)) begin
          members_q[s][low] = 1'b1;
          element_cnt_q++;
        end
      end
      OP_TEST: begin
        s = lookup_slot(key);
        if (s >= 0 && members_q[s].exists(low)) res.found = 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < NumSlots; i++) begin
          slot_used_q[i] = 1'b0;
          members_q[i].delete();
        end
        element_cnt_q = '0;
      end
      default: ;
    endcase
    res.total = element_cnt_q;
    return res;
  endfunction

  initial begin
    element_cnt_q = '0;
    for (int i = 0; i < NumSlots; i++) slot_used_q[i] = 1'b0;
  end

  assign pending_o = expected_results.size();
  assign fails_o   = fail_cnt;

  always @(posedge clk_i) begin
    set_result_t want;
    int          errs;
    errs = 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_results.push_back(apply_set_op(op_e'(kind_i), value_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (found_i !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_i);
            errs++;
          end
          if (total_count_i !== want.total) begin
            $error("total_count: expected %0d, got %0d", want.total, total_count_i);
            errs++;
          end
          if (dropped_i !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, dropped_i);
            errs++;
          end
        end
      end
    end
    if (errs != 0) fail_cnt <= fail_cnt + errs;
  end

endmodule

### bench/tb_top.sv
// Testbench top of the roaring bitmap set: stimulus, receiver stalls, watchdog, verdict.
module tb_top;
  import rbs_pkg::*;

  localparam logic [1:0] KindNone   = 2'(OP_NONE);
  localparam int         IdleLimit  = 40000;  // covers a full array-to-dense conversion
  localparam int         FillCount  = 8;      // ARRAY_LIMIT of the block under test

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        kind = '0;
  logic [31:0]       value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              found;
  logic [TotalW-1:0] total_count;
  logic              dropped;
  int                pending;
  int                fails;

  int                burst_left = 0;
  logic [KeyW-1:0]   key_pool [20];
  logic [LowW-1:0]   low_pool [8];

  initial forever #4 clk = ~clk;

  roaring_bitmap_set_top #(
    .ARRAY_LIMIT (FillCount)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (kind),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .found_o       (found),
    .total_count_o (total_count),
    .dropped_o     (dropped)
  );

  rbs_result_check i_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .kind_i        (kind),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .found_i       (found),
    .total_count_i (total_count),
    .dropped_i     (dropped),
    .pending_o     (pending),
    .fails_o       (fails)
  );

  // Receiver: mode_cnt sets when a new mode is picked - always ready, coin flip, or mostly stalled.
  int unsigned stall_mode = 0;
  int unsigned mode_cnt = 0;
  always @(posedge clk) begin
    mode_cnt <= mode_cnt + 1;
    if (mode_cnt % 64 == 0) stall_mode <= $urandom_range(2);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(1);
      default: out_ready <= ($urandom_range(7) == 0);
    endcase
  end

  // Watchdog: any accepted item on either side restarts the count.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("roaring_bitmap_set_top test failed");
      $finish;
    end
  end

  // Offer one item; the sender runs in bursts with random gaps between them.
  // in_ready is sampled at the falling edge, where it is settled for the next rise.
  task automatic send_item(input logic [1:0] k, input logic [31:0] v);
    logic rdy;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    burst_left--;
  endtask

  // Hold the sender off until every outstanding result is back.
  // The falling edge lets the checker log the item taken at the last rise.
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [15:0] k;
    logic [15:0] l;
    k = ($urandom_range(9) == 0) ? 16'($urandom) : key_pool[$urandom_range(19)];
    l = ($urandom_range(9) < 6) ? low_pool[$urandom_range(7)] : 16'($urandom);
    return {k, l};
  endfunction

  initial begin
    int          r;
    logic [15:0] fill_key;
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    foreach (low_pool[i]) low_pool[i] = 16'($urandom);
    low_pool[0] = 16'h0000;
    low_pool[1] = 16'hFFFF;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, duplicates, unknown kind, clear.
    send_item(KindTest,  32'h0000_0000);
    send_item(KindAdd,   32'h0000_0000);
    send_item(KindAdd,   32'hFFFF_FFFF);
    send_item(KindAdd,   32'hFFFF_FFFF);
    send_item(KindTest,  32'hFFFF_FFFF);
    send_item(KindTest,  32'hFFFF_0000);
    send_item(KindNone,  32'hFFFF_FFFF);
    send_item(KindAdd,   32'h0000_8001);
    send_item(KindTest,  32'h0000_8001);
    send_item(KindClear, 32'hA5A5_5A5A);
    send_item(KindTest,  32'h0000_0000);
    // Full slot table: sixteen keys fit, the seventeenth add is refused.
    for (int i = 0; i < 17; i++) send_item(KindAdd, {16'(i * 4099), 16'(i)});
    send_item(KindTest, {16'(16 * 4099), 16'd16});
    drain();
    send_item(KindClear, 32'h0);

    // Fill one slot's array in ascending order (cheap inserts), then a duplicate
    // add on the full array forces the dense form.
    fill_key = 16'($urandom);
    for (int i = 0; i < FillCount; i++)
      send_item(KindAdd, {fill_key, 16'(i * 16 + $urandom_range(15))});
    send_item(KindAdd, {fill_key, 16'h0000 + 16'(value[15:0])});
    send_item(KindTest, {fill_key, value[15:0]});
    for (int i = 0; i < 10; i++) begin
      r = $urandom_range(1);
      send_item(r ? KindAdd : KindTest, {fill_key, 16'($urandom)});
    end
    drain();

    // Second conversion, this time triggered by a new value.
    send_item(KindClear, 32'h0);
    for (int i = 0; i < FillCount; i++)
      send_item(KindAdd, {key_pool[2], 16'(i * 16 + 1)});
    send_item(KindAdd, {key_pool[2], 16'h0002});
    send_item(KindTest, {key_pool[2], 16'h0002});
    send_item(KindTest, {key_pool[2], 16'h0011});
    send_item(KindTest, {key_pool[2], 16'h0003});

    // Random: mostly adds and tests on a small key/low pool to reach duplicates,
    // hits and a full table; a few clears, unknown kinds and raw values.
    for (int i = 0; i < 80; i++) begin
      r = $urandom_range(99);
      if (r < 45)      send_item(KindAdd,   pick_value());
      else if (r < 82) send_item(KindTest,  pick_value());
      else if (r < 87) send_item(KindClear, $urandom);
      else if (r < 92) send_item(KindNone,  $urandom);
      else             send_item(2'($urandom_range(1)), $urandom);
      if (i == 40) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("roaring_bitmap_set_top test passed");
    end else begin
      $display("roaring_bitmap_set_top test failed");
    end
    $finish;
  end

endmodule
